@@ sv/chm_pkg.sv @@
// shared types and codes for the chained hash map
package chm_pkg;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_SPARE  = 2'd3
	} op_t;

endpackage

@@ sv/chm_ram.sv @@
// generic single-port ram with registered read
module chm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read before write on the same address, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ sv/chained_hash_map.sv @@
// chained hash map: key to value store with per-bucket linked chains
// Slave beat (s_axis): tdata = {value, key, operation}, 66 bits padded to 72.
// Master beat (m_axis): tdata = {entry_count, status, value_out, found}, 43 bits
// padded to 48. One result beat per request beat.
// Bucket is key modulo BUCKETS (low bits of the key when BUCKETS is a power of
// two; otherwise a compare and subtract loop over shifted multiples of the
// bucket count).
// One request at a time: s_axis_tready is high only in the idle state.
// The result beat follows the bucket reduction, the head read and, per chain
// step, one read of the shared entry ram and one key compare, up to the match
// or, on a miss, over the whole chain. An insert of a new key adds a pop from
// the free stack, an append and a link; a remove that hits adds the relink of
// its predecessor or head and a push onto the free stack. The next request
// beat is taken in the cycle after the result beat.
// After reset a clearing pass writes the empty marker to every bucket head and
// fills the free stack with every entry index; no request is taken during
// the pass.
// The result is held in an output register; while the receiver stalls the
// block waits and accepts nothing new.
module chained_hash_map
	import chm_pkg::*;
#(
	parameter int BUCKETS = 64,
	parameter int ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // operation[1:0], key[33:2], value[65:34]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // found[0], value_out[32:1], status[33],
	                                   // entry_count[42:34]
);

	localparam int EW = $clog2(ENTRIES);
	localparam int PW = EW + 1;
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int BD = (BUCKETS > 1) ? BUCKETS : 2;
	localparam int CW = (PW > BW) ? PW : BW + 1;
	localparam int NW = 32 + 32 + PW;
	localparam logic [PW-1:0] EMPTY = PW'(ENTRIES);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_HASH, ST_HEAD_RD, ST_HEAD_WT, ST_ENT_WT,
		ST_CMP, ST_POP_WT, ST_APPEND, ST_LINK, ST_PUSH, ST_OUT
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   clr_q;
	op_t             op_q;
	logic [31:0]     key_q, val_q, rem_q;
	logic [PW-1:0]   cur_q, prev_q, newn_q, free_top_q, held_q;
	logic [EW:0]     steps_q;
	logic            found_q, status_q;
	logic [31:0]     vout_q;

	// ram ports
	logic             hd_we, en_we, fs_we;
	logic [BW-1:0]    hd_addr;
	logic [PW-1:0]    hd_wdata, hd_rdata;
	logic [EW-1:0]    en_addr, fs_addr;
	logic [NW-1:0]    en_wdata, en_rdata;
	logic [EW-1:0]    fs_wdata, fs_rdata;

	logic [31:0] e_key, e_val;
	logic [PW-1:0] e_next;
	assign e_key  = en_rdata[31:0];
	assign e_val  = en_rdata[63:32];
	assign e_next = en_rdata[NW-1:64];

	chm_ram #(.WIDTH(PW), .DEPTH(BD)) u_head (
		.clk(clk), .we(hd_we), .addr(hd_addr), .wdata(hd_wdata), .rdata(hd_rdata));
	chm_ram #(.WIDTH(NW), .DEPTH(ENTRIES)) u_entry (
		.clk(clk), .we(en_we), .addr(en_addr), .wdata(en_wdata), .rdata(en_rdata));
	chm_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_free (
		.clk(clk), .we(fs_we), .addr(fs_addr), .wdata(fs_wdata), .rdata(fs_rdata));

	logic [BW-1:0] bucket;
	assign bucket = BW'(rem_q);

	logic link_prev;
	assign link_prev = (prev_q != EMPTY);

	// ram port steering
	always_comb begin
		hd_we    = 1'b0;
		hd_addr  = bucket;
		hd_wdata = EMPTY;
		en_we    = 1'b0;
		en_addr  = cur_q[EW-1:0];
		en_wdata = en_rdata;
		fs_we    = 1'b0;
		fs_addr  = EW'(free_top_q - PW'(1));
		fs_wdata = cur_q[EW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				hd_we    = (clr_q < CW'(BD));
				hd_addr  = BW'(clr_q);
				hd_wdata = EMPTY;
				fs_we    = (clr_q < CW'(ENTRIES));
				fs_addr  = EW'(clr_q);
				fs_wdata = EW'(clr_q);
			end
			ST_CMP: begin
				// overwrite value on insert hit
				if (cur_q != EMPTY && e_key == key_q && op_q == OP_INSERT) begin
					en_we    = 1'b1;
					en_wdata = {e_next, val_q, e_key};
				end
			end
			ST_APPEND: begin
				en_we    = 1'b1;
				en_addr  = fs_rdata;
				en_wdata = {EMPTY, val_q, key_q};
			end
			ST_LINK: begin
				// point head at target in newn_q, or read predecessor for its rewrite in ST_PUSH
				if (link_prev) begin
					en_addr = prev_q[EW-1:0];
				end else begin
					hd_we    = 1'b1;
					hd_wdata = newn_q;
				end
			end
			ST_PUSH: begin
				if (link_prev) begin
					en_we    = 1'b1;
					en_addr  = prev_q[EW-1:0];
					en_wdata = {newn_q, en_rdata[63:0]};
				end
				// removed entry goes onto the free stack at the current top
				fs_we    = (op_q == OP_REMOVE) && (free_top_q < PW'(ENTRIES));
				fs_addr  = EW'(free_top_q);
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			free_top_q    <= PW'(ENTRIES);
			held_q        <= '0;
			m_axis_tvalid <= 1'b0;
			s_axis_tready <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CW'(BD - 1) || clr_q == CW'(ENTRIES - 1)) begin
						if (!(clr_q < CW'(BD - 1)) && !(clr_q < CW'(ENTRIES - 1))) begin
							state_q       <= ST_IDLE;
							s_axis_tready <= 1'b1;
						end
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						s_axis_tready <= 1'b0;
						op_q    <= op_t'(s_axis_tdata[1:0]);
						key_q   <= s_axis_tdata[33:2];
						val_q   <= s_axis_tdata[65:34];
						rem_q   <= s_axis_tdata[33:2];
						prev_q  <= EMPTY;
						steps_q <= '0;
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					// reduce key modulo bucket count: a mask for a power of two, else one compare and subtract a cycle
					if ((BUCKETS & (BUCKETS - 1)) == 0) begin
						rem_q   <= rem_q & 32'(BUCKETS - 1);
						state_q <= ST_HEAD_RD;
					end else if (64'(rem_q) >= (64'(BUCKETS) << 25)) begin
						rem_q <= rem_q - 32'(64'(BUCKETS) << 25);
					end else if (64'(rem_q) >= (64'(BUCKETS) << 20)) begin
						rem_q <= rem_q - 32'(64'(BUCKETS) << 20);
					end else if (64'(rem_q) >= (64'(BUCKETS) << 15)) begin
						rem_q <= rem_q - 32'(64'(BUCKETS) << 15);
					end else if (64'(rem_q) >= (64'(BUCKETS) << 10)) begin
						rem_q <= rem_q - 32'(64'(BUCKETS) << 10);
					end else if (64'(rem_q) >= (64'(BUCKETS) << 5)) begin
						rem_q <= rem_q - 32'(64'(BUCKETS) << 5);
					end else if (rem_q >= 32'(BUCKETS)) begin
						rem_q <= rem_q - 32'(BUCKETS);
					end else begin
						state_q <= ST_HEAD_RD;
					end
				end
				ST_HEAD_RD: state_q <= ST_HEAD_WT;
				ST_HEAD_WT: begin
					cur_q   <= hd_rdata;
					state_q <= ST_ENT_WT;
				end
				ST_ENT_WT: state_q <= ST_CMP;
				ST_CMP: begin
					if (cur_q != EMPTY && steps_q != (EW + 1)'(ENTRIES) && e_key == key_q) begin
						found_q  <= 1'b1;
						status_q <= 1'b0;
						vout_q   <= (op_q == OP_LOOKUP || op_q == OP_SPARE) ? e_val : 32'd0;
						if (op_q == OP_REMOVE) begin
							newn_q  <= e_next;
							state_q <= ST_LINK;
							if (held_q != '0) held_q <= held_q - PW'(1);
						end else begin
							state_q <= ST_OUT;
						end
					end else if (cur_q != EMPTY && steps_q != (EW + 1)'(ENTRIES)) begin
						prev_q  <= cur_q;
						cur_q   <= e_next;
						steps_q <= steps_q + (EW + 1)'(1);
						state_q <= ST_ENT_WT;
					end else begin
						found_q  <= 1'b0;
						vout_q   <= 32'd0;
						status_q <= (op_q == OP_INSERT) && (free_top_q == '0);
						if (op_q == OP_INSERT && free_top_q != '0) begin
							state_q <= ST_POP_WT;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_POP_WT: state_q <= ST_APPEND;
				ST_APPEND: begin
					newn_q     <= {1'b0, fs_rdata};
					free_top_q <= free_top_q - PW'(1);
					held_q     <= held_q + PW'(1);
					state_q    <= ST_LINK;
				end
				ST_LINK: state_q <= ST_PUSH;
				ST_PUSH: begin
					// free stack grows after the push of a removed entry
					if (op_q == OP_REMOVE && free_top_q < PW'(ENTRIES)) begin
						free_top_q <= free_top_q + PW'(1);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_axis_tvalid && m_axis_tready) begin
						m_axis_tvalid <= 1'b0;
						s_axis_tready <= 1'b1;
						state_q       <= ST_IDLE;
					end else begin
						m_axis_tvalid <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tdata = {5'd0, 9'(held_q), status_q, vout_q, found_q};

	// checks
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= PW'(ENTRIES)) else $error("held count beyond pool size");
	a_pool_sum: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> free_top_q + held_q == PW'(ENTRIES))
		else $error("free and held entries do not add up");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");

endmodule
